// ----- rtl/rmca_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmca_pkg
// shared types and constants of the region mean and centroid accumulator
// ----------------------------------------------------------------------------
package rmca_pkg;

    localparam logic [1:0] REQ_ACCUM = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] CFG_LABEL_MIN    = 2'd0;
    localparam logic [1:0] CFG_REGION_COUNT = 2'd1;
    localparam logic [1:0] CFG_MASK_ENABLE  = 2'd2;
    localparam logic [1:0] CFG_FRAME_COUNT  = 2'd3;

    localparam int SUM_W = 40;
    localparam logic signed [15:0] EMPTY_CENTROID = -16'sd10000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] roi_label;
        logic        mask_bit;
        logic [5:0]  frame_index;
        logic signed [15:0] sample_value;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [7:0]  query_region;
    } req_t;

    typedef struct packed {
        logic signed [15:0] mean_value;
        logic signed [15:0] centroid_x;
        logic signed [15:0] centroid_y;
        logic signed [15:0] centroid_z;
        logic [23:0] voxel_count;
        logic        region_empty;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture item, issue memory reads
        logic write;     // write back accumulate result
        logic clr_step;  // clear one address
        logic div_start;
        logic out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic acc_ok;
    } sts_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a, input logic signed [15:0] b);
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {{(SUM_W-15){b[15]}}, b};
        if (s[SUM_W] != s[SUM_W-1])
            return s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        return s[SUM_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/rmca_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmca_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface rmca_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/rmca_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmca_divider
// signed 40 bit by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero and saturated to 16 bits
// ----------------------------------------------------------------------------
module rmca_divider #(
    parameter int COUNT_BITS = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic signed [rmca_pkg::SUM_W-1:0] dividend,
    input  wire logic [COUNT_BITS-1:0] divisor,
    output logic done,
    output logic signed [15:0] quotient
);
    localparam int W = rmca_pkg::SUM_W;
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] quo_reg, quo_next;
    logic [COUNT_BITS:0] rem_reg, rem_next;
    logic [COUNT_BITS-1:0] den_reg;
    logic neg_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg;
    logic [COUNT_BITS:0] trial;
    logic [W-1:0] mag;

    assign mag = dividend[W-1] ? (~dividend + 1'b1) : dividend;

    always_comb
    begin
        trial = {rem_reg[COUNT_BITS-1:0], quo_reg[W-1]};
        quo_next = {quo_reg[W-2:0], 1'b0};
        rem_next = trial;
        if (trial >= {1'b0, den_reg})
        begin
            rem_next = trial - {1'b0, den_reg};
            quo_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= dividend[W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // magnitude saturation then sign
    always_comb
    begin
        if (neg_reg)
            quotient = (quo_reg > W'(32768)) ? -16'sd32768 : 16'(~quo_reg + 1'b1);
        else
            quotient = (quo_reg > W'(32767)) ? 16'sd32767 : 16'(quo_reg);
    end
endmodule
`default_nettype wire

// ----- rtl/rmca_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmca_datapath
// sum memories, accumulate write back, clear sweep and four dividers
// ----------------------------------------------------------------------------
module rmca_datapath #(
    parameter int MAX_REGIONS = 256,
    parameter int MAX_FRAMES  = 64,
    parameter int COUNT_BITS  = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire rmca_pkg::cmd_t cmd,
    output rmca_pkg::sts_t sts,
    input  wire rmca_pkg::req_t req,
    input  wire logic [15:0] label_min,
    input  wire logic [8:0]  region_count,
    input  wire logic        mask_enable,
    input  wire logic [6:0]  frame_count,
    output rmca_pkg::rsp_t rsp
);
    localparam int W  = rmca_pkg::SUM_W;
    localparam int RW = $clog2(MAX_REGIONS);
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int AW = RW + FW;
    // frame field of the address is a full power of two wide
    localparam int FD = MAX_REGIONS << FW;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    logic signed [W-1:0] fs_mem [FD];
    logic signed [W-1:0] sx_mem [MAX_REGIONS];
    logic signed [W-1:0] sy_mem [MAX_REGIONS];
    logic signed [W-1:0] sz_mem [MAX_REGIONS];
    logic [COUNT_BITS-1:0] cn_mem [MAX_REGIONS];

    logic signed [W-1:0] fs_rd, sx_rd, sy_rd, sz_rd;
    logic [COUNT_BITS-1:0] cn_rd;

    rmca_pkg::req_t item_reg;
    logic [RW-1:0] reg_idx_reg;
    logic [FW-1:0] frm_idx_reg;
    logic acc_ok_reg, frm_ok_reg, q_ok_reg;
    logic [AW-1:0] clr_reg;

    // accumulate gating
    logic [16:0] region_s;
    logic acc_ok, frm_ok, q_ok;
    logic [RW-1:0] r_idx;
    logic [FW-1:0] f_idx;

    always_comb
    begin
        region_s = {1'b0, req.roi_label} - {1'b0, label_min} - 17'd1;
        frm_ok = ({1'b0, req.frame_index} < frame_count) &&
                 (32'(req.frame_index) < MAX_FRAMES);
        acc_ok = !(mask_enable && !req.mask_bit) && !region_s[16] &&
                 (32'(region_s[15:0]) < MAX_REGIONS) && frm_ok;
        q_ok = ({1'b0, req.query_region} < region_count) &&
               (32'(req.query_region) < MAX_REGIONS);
        if (req.req_type == rmca_pkg::REQ_QUERY)
            r_idx = RW'(req.query_region);
        else
            r_idx = RW'(region_s[15:0]);
        f_idx = FW'(req.frame_index);
    end

    logic [AW-1:0] rd_addr, wr_addr;
    assign rd_addr = {r_idx, f_idx};
    assign wr_addr = {reg_idx_reg, frm_idx_reg};
    logic clr_active;
    assign clr_active = cmd.clr_step;

    logic cnt_ok;
    assign cnt_ok = (frm_idx_reg == '0) && (cn_rd != CMAX);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fs_rd <= fs_mem[rd_addr];
            sx_rd <= sx_mem[r_idx];
            sy_rd <= sy_mem[r_idx];
            sz_rd <= sz_mem[r_idx];
            cn_rd <= cn_mem[r_idx];
            item_reg <= req;
            reg_idx_reg <= r_idx;
            frm_idx_reg <= f_idx;
            frm_ok_reg <= frm_ok;
            q_ok_reg <= q_ok;
        end
        if (clr_active)
        begin
            fs_mem[clr_reg] <= '0;
            if (clr_reg < AW'(MAX_REGIONS))
            begin
                sx_mem[RW'(clr_reg)] <= '0;
                sy_mem[RW'(clr_reg)] <= '0;
                sz_mem[RW'(clr_reg)] <= '0;
                cn_mem[RW'(clr_reg)] <= '0;
            end
        end
        else if (cmd.write && acc_ok_reg)
        begin
            fs_mem[wr_addr] <= rmca_pkg::sat_add(fs_rd, item_reg.sample_value);
            if (cnt_ok)
            begin
                sx_mem[reg_idx_reg] <= rmca_pkg::sat_add(sx_rd, item_reg.pos_x);
                sy_mem[reg_idx_reg] <= rmca_pkg::sat_add(sy_rd, item_reg.pos_y);
                sz_mem[reg_idx_reg] <= rmca_pkg::sat_add(sz_rd, item_reg.pos_z);
                cn_mem[reg_idx_reg] <= cn_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            acc_ok_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                acc_ok_reg <= acc_ok && (req.req_type == rmca_pkg::REQ_ACCUM);
            if (clr_active)
                clr_reg <= (clr_reg == AW'(FD - 1)) ? '0 : clr_reg + 1'b1;
        end
    end

    assign sts.clr_done = clr_reg == AW'(FD - 1);
    assign sts.acc_ok   = acc_ok_reg;

    // query division
    logic [COUNT_BITS-1:0] n_eff;
    logic empty;
    assign n_eff = q_ok_reg ? cn_rd : '0;
    assign empty = n_eff == '0;

    logic [3:0] dv_done;
    logic signed [15:0] q_m, q_x, q_y, q_z;

    rmca_divider #(.COUNT_BITS(COUNT_BITS)) u_div_m (.clk(clk), .rst_n(rst_n),
        .start(cmd.div_start), .dividend(fs_rd), .divisor(n_eff),
        .done(dv_done[0]), .quotient(q_m));
    rmca_divider #(.COUNT_BITS(COUNT_BITS)) u_div_x (.clk(clk), .rst_n(rst_n),
        .start(cmd.div_start), .dividend(sx_rd), .divisor(n_eff),
        .done(dv_done[1]), .quotient(q_x));
    rmca_divider #(.COUNT_BITS(COUNT_BITS)) u_div_y (.clk(clk), .rst_n(rst_n),
        .start(cmd.div_start), .dividend(sy_rd), .divisor(n_eff),
        .done(dv_done[2]), .quotient(q_y));
    rmca_divider #(.COUNT_BITS(COUNT_BITS)) u_div_z (.clk(clk), .rst_n(rst_n),
        .start(cmd.div_start), .dividend(sz_rd), .divisor(n_eff),
        .done(dv_done[3]), .quotient(q_z));

    assign sts.div_done = dv_done[0];

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (empty)
            begin
                rsp.mean_value <= '0;
                rsp.centroid_x <= rmca_pkg::EMPTY_CENTROID;
                rsp.centroid_y <= rmca_pkg::EMPTY_CENTROID;
                rsp.centroid_z <= rmca_pkg::EMPTY_CENTROID;
                rsp.voxel_count <= '0;
                rsp.region_empty <= 1'b1;
            end
            else
            begin
                rsp.mean_value <= frm_ok_reg ? q_m : 16'sd0;
                rsp.centroid_x <= q_x;
                rsp.centroid_y <= q_y;
                rsp.centroid_z <= q_z;
                if (COUNT_BITS > 24 && (n_eff >> 24) != '0)
                    rsp.voxel_count <= 24'hFFFFFF;
                else
                    rsp.voxel_count <= 24'(n_eff);
                rsp.region_empty <= 1'b0;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !dv_done[0])
        else $error("divider done right after start");
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(dv_done) || dv_done == 4'hF)
        else $error("dividers out of step");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.write && cmd.clr_step))
        else $error("write back during clear sweep");
endmodule
`default_nettype wire

// ----- rtl/rmca_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmca_ctrl
// request sequencer: clear sweep, accumulate read/write, query divide
// ----------------------------------------------------------------------------
module rmca_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic [1:0] req_type,
    output logic      out_valid,
    input  wire logic out_ready,
    output rmca_pkg::cmd_t cmd,
    input  wire rmca_pkg::sts_t sts
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic take;

    assign out_valid = out_valid_reg;
    // a query may enter while the previous result waits, but results only load once taken
    assign in_ready = (state_reg == ST_IDLE);
    assign take = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    cmd.load = 1'b1;
                    case (req_type)
                        rmca_pkg::REQ_ACCUM: state_next = ST_WRITE;
                        rmca_pkg::REQ_QUERY: state_next = ST_DIV0;
                        rmca_pkg::REQ_CLEAR: state_next = ST_CLEAR;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:
            begin
                cmd.write = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DIV0:
            begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result loaded but not shown");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |-> $past(take))
        else $error("write back without item");
endmodule
`default_nettype wire

// ----- rtl/roi_mean_centroid_accumulator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// roi_mean_centroid_accumulator
// per region sums of labelled voxel samples and positions, with mean and
// centroid queries
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   valid/ready        rmca_pkg::req_t
//  rsp      out  valid/ready        rmca_pkg::rsp_t
//  cfg      in   cfg_we             cfg_index, cfg_data
//
//  accumulate: memory read, then write back; unused codes are taken and dropped
//  query: memory read, divider start, the 40 step bit serial dividers, result load
//  clear and reset: sweep of MAX_REGIONS times MAX_FRAMES (rounded up to a
//  power of two) addresses, no item taken
//  a stalled result holds; the next query computes, then waits for it to go
// ----------------------------------------------------------------------------
module roi_mean_centroid_accumulator #(
    parameter int MAX_REGIONS = 256,
    parameter int MAX_FRAMES  = 64,
    parameter int COUNT_BITS  = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    rmca_stream_if.sink   req,
    rmca_stream_if.source rsp,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic [15:0] label_min_reg;
    logic [8:0]  region_count_reg;
    logic        mask_enable_reg;
    logic [6:0]  frame_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_min_reg    <= '0;
            region_count_reg <= 9'd256;
            mask_enable_reg  <= 1'b0;
            frame_count_reg  <= 7'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rmca_pkg::CFG_LABEL_MIN:    label_min_reg    <= cfg_data;
                rmca_pkg::CFG_REGION_COUNT: region_count_reg <= cfg_data[8:0];
                rmca_pkg::CFG_MASK_ENABLE:  mask_enable_reg  <= cfg_data[0];
                rmca_pkg::CFG_FRAME_COUNT:  frame_count_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    rmca_pkg::cmd_t cmd;
    rmca_pkg::sts_t sts;
    rmca_pkg::req_t req_data;
    rmca_pkg::rsp_t rsp_data;

    assign req_data = req.data;
    assign rsp.data = rsp_data;

    rmca_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready), .req_type(req_data.req_type),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .cmd(cmd), .sts(sts)
    );

    rmca_datapath #(
        .MAX_REGIONS(MAX_REGIONS), .MAX_FRAMES(MAX_FRAMES), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .req(req_data),
        .label_min(label_min_reg), .region_count(region_count_reg),
        .mask_enable(mask_enable_reg), .frame_count(frame_count_reg),
        .rsp(rsp_data)
    );
endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the region mean and centroid accumulator: items
// go in over the request channel, an in-bench copy of the region store
// predicts every query answer, and the response channel is compared with it
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NREG = 256;
    localparam int NFRM = 64;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam longint SUM_HI = 64'sd549755813887;
    localparam longint SUM_LO = -64'sd549755813888;
    localparam int unsigned CNT_HI = 32'h00FF_FFFF;

    logic clk;
    logic rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    rmca_stream_if #(.T(rmca_pkg::req_t)) req_ch ();
    rmca_stream_if #(.T(rmca_pkg::rsp_t)) rsp_ch ();

    roi_mean_centroid_accumulator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // mirror of the region store and settings
    longint      frame_sum [NREG*NFRM];
    int unsigned vox_cnt [NREG];
    longint      pos_sum_x [NREG];
    longint      pos_sum_y [NREG];
    longint      pos_sum_z [NREG];
    int unsigned lbl_min;
    int unsigned reg_limit;
    bit          mask_on;
    int unsigned frm_limit;

    rmca_pkg::rsp_t pending_rsp[$];
    int   err_count;
    bit   quiet;
    int   stall_left;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic clear_mirror();
        for (int i = 0; i < NREG*NFRM; i++)
            frame_sum[i] = 64'sd0;
        for (int i = 0; i < NREG; i++)
        begin
            vox_cnt[i] = 0;
            pos_sum_x[i] = 64'sd0;
            pos_sum_y[i] = 64'sd0;
            pos_sum_z[i] = 64'sd0;
        end
    endtask

    function automatic longint add_clamped(longint a, logic signed [15:0] b);
        longint s;
        s = a + longint'(b);
        if (s > SUM_HI)
            return SUM_HI;
        if (s < SUM_LO)
            return SUM_LO;
        return s;
    endfunction

    function automatic logic signed [15:0] mean_clamped(longint s, int unsigned n);
        longint q;
        q = s / longint'(n);
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return q[15:0];
    endfunction

    task automatic predict_region_item(rmca_pkg::req_t it);
        int   region;
        int unsigned r;
        int unsigned n;
        rmca_pkg::rsp_t exp_rsp;
        case (it.req_type)
            rmca_pkg::REQ_ACCUM:
            begin
                region = int'(it.roi_label) - int'(lbl_min) - 1;
                if (mask_on && !it.mask_bit)
                    return;
                if (region < 0 || region >= NREG)
                    return;
                if (32'(it.frame_index) >= frm_limit)
                    return;
                r = unsigned'(region);
                frame_sum[r*NFRM + it.frame_index] =
                    add_clamped(frame_sum[r*NFRM + it.frame_index], it.sample_value);
                if (it.frame_index == 6'd0 && vox_cnt[r] < CNT_HI)
                begin
                    pos_sum_x[r] = add_clamped(pos_sum_x[r], it.pos_x);
                    pos_sum_y[r] = add_clamped(pos_sum_y[r], it.pos_y);
                    pos_sum_z[r] = add_clamped(pos_sum_z[r], it.pos_z);
                    vox_cnt[r]++;
                end
            end
            rmca_pkg::REQ_QUERY:
            begin
                r = 32'(it.query_region);
                n = (r < reg_limit) ? vox_cnt[r] : 0;
                if (n == 0)
                begin
                    exp_rsp.mean_value   = '0;
                    exp_rsp.centroid_x   = rmca_pkg::EMPTY_CENTROID;
                    exp_rsp.centroid_y   = rmca_pkg::EMPTY_CENTROID;
                    exp_rsp.centroid_z   = rmca_pkg::EMPTY_CENTROID;
                    exp_rsp.voxel_count  = '0;
                    exp_rsp.region_empty = 1'b1;
                end
                else
                begin
                    exp_rsp.mean_value = (32'(it.frame_index) < frm_limit) ?
                        mean_clamped(frame_sum[r*NFRM + it.frame_index], n) : '0;
                    exp_rsp.centroid_x   = mean_clamped(pos_sum_x[r], n);
                    exp_rsp.centroid_y   = mean_clamped(pos_sum_y[r], n);
                    exp_rsp.centroid_z   = mean_clamped(pos_sum_z[r], n);
                    exp_rsp.voxel_count  = n[23:0];
                    exp_rsp.region_empty = 1'b0;
                end
                pending_rsp.push_back(exp_rsp);
            end
            rmca_pkg::REQ_CLEAR:
                clear_mirror();
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // response side: random stalls, sampled at the rising edge
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= (stall_left == 0);
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left = int'($urandom_range(1, 15));
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        rmca_pkg::rsp_t got;
        rmca_pkg::rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_rsp.size() == 0)
                report_mismatch("result count", longint'(1), longint'(0));
            else
            begin
                want = pending_rsp.pop_front();
                if (got.mean_value !== want.mean_value)
                    report_mismatch("mean_value", longint'(got.mean_value),
                                    longint'(want.mean_value));
                if (got.centroid_x !== want.centroid_x)
                    report_mismatch("centroid_x", longint'(got.centroid_x),
                                    longint'(want.centroid_x));
                if (got.centroid_y !== want.centroid_y)
                    report_mismatch("centroid_y", longint'(got.centroid_y),
                                    longint'(want.centroid_y));
                if (got.centroid_z !== want.centroid_z)
                    report_mismatch("centroid_z", longint'(got.centroid_z),
                                    longint'(want.centroid_z));
                if (got.voxel_count !== want.voxel_count)
                    report_mismatch("voxel_count", longint'(got.voxel_count),
                                    longint'(want.voxel_count));
                if (got.region_empty !== want.region_empty)
                    report_mismatch("region_empty", longint'(got.region_empty),
                                    longint'(want.region_empty));
            end
        end
    end

    task automatic send_item(rmca_pkg::req_t it);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = int'($urandom_range(1, 15));
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= it;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predict_region_item(it);
    endtask

    task automatic release_req();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    function automatic rmca_pkg::req_t make_item(logic [1:0] kind, logic [15:0] label,
                                       logic mask, logic [5:0] frame,
                                       logic signed [15:0] smp, logic signed [15:0] x,
                                       logic signed [15:0] y, logic signed [15:0] z,
                                       logic [7:0] qreg);
        rmca_pkg::req_t it;
        it.req_type     = kind;
        it.roi_label    = label;
        it.mask_bit     = mask;
        it.frame_index  = frame;
        it.sample_value = smp;
        it.pos_x        = x;
        it.pos_y        = y;
        it.pos_z        = z;
        it.query_region = qreg;
        return it;
    endfunction

    function automatic rmca_pkg::req_t query_of(int unsigned region, int unsigned frame);
        return make_item(rmca_pkg::REQ_QUERY, 16'($urandom), 1'($urandom), 6'(frame),
                         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         8'(region));
    endfunction

    // a query at the end guarantees any clear sweep is over before we go idle
    task automatic settle();
        send_item(query_of(0, 0));
        release_req();
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, int unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[15:0];
        @(posedge clk);
        case (idx)
            rmca_pkg::CFG_LABEL_MIN:    lbl_min   = val & 32'h0000_FFFF;
            rmca_pkg::CFG_REGION_COUNT: reg_limit = val & 32'h0000_01FF;
            rmca_pkg::CFG_MASK_ENABLE:  mask_on   = val[0];
            rmca_pkg::CFG_FRAME_COUNT:  frm_limit = val & 32'h0000_007F;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(int unsigned lmin, int unsigned rcnt, bit men,
                              int unsigned fcnt);
        write_cfg(rmca_pkg::CFG_LABEL_MIN, lmin);
        write_cfg(rmca_pkg::CFG_REGION_COUNT, rcnt);
        write_cfg(rmca_pkg::CFG_MASK_ENABLE, 32'(men));
        write_cfg(rmca_pkg::CFG_FRAME_COUNT, fcnt);
    endtask

    task automatic test_directed();
        settle();
        set_config(0, 256, 1'b1, 64);
        // empty regions at both ends
        send_item(query_of(0, 0));
        send_item(query_of(255, 63));
        // extremes of sample and position into region 0, a small item into region 255
        send_item(make_item(rmca_pkg::REQ_ACCUM, 16'd1, 1'b1, 6'd0, 16'sh7FFF, 16'sh7FFF,
                            16'sh8000, 16'sh7FFF, 8'd0));
        send_item(make_item(rmca_pkg::REQ_ACCUM, 16'd1, 1'b1, 6'd0, 16'sh8000, 16'sh8000,
                            16'sh7FFF, 16'sh8000, 8'd0));
        send_item(make_item(rmca_pkg::REQ_ACCUM, 16'd1, 1'b1, 6'd63, 16'sh7FFF, 16'sd0,
                            16'sd0, 16'sd0, 8'd0));
        send_item(make_item(rmca_pkg::REQ_ACCUM, 16'd256, 1'b1, 6'd0, -16'sd7, 16'sd3,
                            -16'sd3, 16'sd5, 8'd0));
        // masked voxel, negative region, label beyond store
        send_item(make_item(rmca_pkg::REQ_ACCUM, 16'd1, 1'b0, 6'd0, 16'sd999, 16'sd9,
                            16'sd9, 16'sd9, 8'd0));
        send_item(make_item(rmca_pkg::REQ_ACCUM, 16'd0, 1'b1, 6'd0, 16'sd999, 16'sd9,
                            16'sd9, 16'sd9, 8'd0));
        send_item(make_item(rmca_pkg::REQ_ACCUM, 16'hFFFF, 1'b1, 6'd0, 16'sd999, 16'sd9,
                            16'sd9, 16'sd9, 8'd0));
        send_item(make_item(REQ_UNUSED, 16'd1, 1'b1, 6'd0, 16'sd999, 16'sd9,
                            16'sd9, 16'sd9, 8'd0));
        send_item(query_of(0, 0));
        send_item(query_of(0, 63));
        send_item(query_of(255, 0));
        settle();
        // frame out of range, query beyond region count
        set_config(0, 1, 1'b0, 1);
        send_item(make_item(rmca_pkg::REQ_ACCUM, 16'd2, 1'b0, 6'd5, 16'sd50, 16'sd1,
                            16'sd1, 16'sd1, 8'd0));
        send_item(make_item(rmca_pkg::REQ_ACCUM, 16'd2, 1'b0, 6'd0, 16'sd50, 16'sd1,
                            16'sd1, 16'sd1, 8'd0));
        send_item(query_of(0, 5));
        send_item(query_of(1, 0));
        send_item(make_item(rmca_pkg::REQ_CLEAR, 16'd0, 1'b0, 6'd0, 16'sd0, 16'sd0,
                            16'sd0, 16'sd0, 8'd0));
        send_item(query_of(0, 0));
        settle();
    endtask

    task automatic test_random(int n_items, int unsigned lmin, int unsigned rcnt,
                               bit men, int unsigned fcnt);
        rmca_pkg::req_t it;
        int unsigned pick;
        int unsigned hot;
        set_config(lmin, rcnt, men, fcnt);
        hot = $urandom_range(1, 12);
        for (int i = 0; i < n_items; i++)
        begin
            it = make_item(2'($urandom), 16'($urandom), 1'($urandom), 6'($urandom),
                           16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                           8'($urandom));
            pick = $urandom_range(0, 999);
            if (pick < 600)
            begin
                it.req_type = rmca_pkg::REQ_ACCUM;
                // mostly valid labels in a few busy regions
                if ($urandom_range(0, 9) < 8)
                    it.roi_label = 16'(lmin + 1 + $urandom_range(0, hot - 1));
                if ($urandom_range(0, 9) < 8)
                    it.frame_index = 6'($urandom_range(0, fcnt > 0 ? fcnt - 1 : 0));
                if ($urandom_range(0, 3) == 0)
                    it.frame_index = 6'd0;
            end
            else if (pick < 980)
            begin
                it.req_type = rmca_pkg::REQ_QUERY;
                if ($urandom_range(0, 9) < 8)
                    it.query_region = 8'($urandom_range(0, hot));
                if ($urandom_range(0, 9) < 8)
                    it.frame_index = 6'($urandom_range(0, fcnt > 0 ? fcnt - 1 : 0));
            end
            else if (pick < 985)
                it.req_type = rmca_pkg::REQ_CLEAR;
            else
                it.req_type = REQ_UNUSED;
            send_item(it);
        end
        settle();
    endtask

    initial
    begin
        err_count       = 0;
        quiet           = 1'b0;
        stall_left      = 0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.data     = '0;
        rsp_ch.ready    = 1'b1;
        lbl_min         = 0;
        reg_limit       = 256;
        mask_on         = 1'b0;
        frm_limit       = 1;
        clear_mirror();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(250, 0, 256, 1'b0, 1);
        test_random(250, 1000, 256, 1'b1, 64);
        test_random(50, 65535, 256, 1'b0, 64);
        test_random(250, $urandom_range(0, 65000), $urandom_range(1, 256), 1'b1,
                    $urandom_range(1, 64));
        test_random(200, 65279, 1, 1'b0, $urandom_range(1, 64));
        quiet = 1'b1;
        test_random(250, $urandom_range(0, 300), 256, 1'b0, 64);

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rmca_pkg.sv
rtl/rmca_stream_if.sv
rtl/rmca_divider.sv
rtl/rmca_datapath.sv
rtl/rmca_ctrl.sv
rtl/roi_mean_centroid_accumulator.sv
bench/tb_top.sv
